// ----- rtl/core/famd_pkg.sv -----
// Shared types and constants for the truncating float add/multiply/divide unit.
// No dependencies.
package famd_pkg;

  localparam int EXP_BITS_DEF  = 8;
  localparam int FRAC_BITS_DEF = 23;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // control that travels with each pipeline slot
  typedef struct packed {
    logic vld;
    op_t  op;
  } ctl_t;

endpackage

// ----- rtl/core/famd_stage.sv -----
// One iteration stage: a multiply shift-add step, a restoring divide step,
// or a one-place normalize step for add. Depends on famd_pkg.
module famd_stage #(
  parameter int E = famd_pkg::EXP_BITS_DEF,
  parameter int F = famd_pkg::FRAC_BITS_DEF,
  parameter int K = 0,
  localparam int MW = F + 1,
  localparam int AW = 2 * MW + 1,
  localparam int RW = MW + 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  famd_pkg::ctl_t  ctl_i,
  input  logic            sgn_i,
  input  logic [E-1:0]    ex_i,
  input  logic [AW-1:0]   acc_i,
  input  logic [RW-1:0]   rem_i,
  input  logic [MW-1:0]   ma_i,
  input  logic [MW-1:0]   mb_i,
  output famd_pkg::ctl_t  ctl_o,
  output logic            sgn_o,
  output logic [E-1:0]    ex_o,
  output logic [AW-1:0]   acc_o,
  output logic [RW-1:0]   rem_o,
  output logic [MW-1:0]   ma_o,
  output logic [MW-1:0]   mb_o
);
  import famd_pkg::*;

  logic [AW-1:0] acc_nxt, sum;
  logic [RW-1:0] rem_nxt, r2;
  logic [E-1:0]  ex_nxt;
  logic          ge;

  always_comb begin
    acc_nxt = acc_i;
    rem_nxt = rem_i;
    ex_nxt  = ex_i;
    sum     = acc_i;
    r2      = {rem_i[MW-1:0], 1'b0};
    ge      = (r2 >= RW'(mb_i));
    case (ctl_i.op)
      OP_MUL: begin
        if (mb_i[K]) sum = acc_i + (AW'(ma_i) << MW);
        acc_nxt = sum >> 1;
      end
      OP_DIV: begin
        // integer quotient bit is settled before the chain
        if (K != 0) begin
          rem_nxt = ge ? (r2 - RW'(mb_i)) : r2;
          acc_nxt = {acc_i[AW-2:0], ge};
        end
      end
      OP_ADD: begin
        if (acc_i[MW-1:0] != '0 && !acc_i[F]) begin
          acc_nxt = acc_i << 1;
          ex_nxt  = ex_i - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o.vld <= 1'b0;
    end else if (en) begin
      ctl_o.vld <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_o.op <= ctl_i.op;
      sgn_o    <= sgn_i;
      ex_o     <= ex_nxt;
      acc_o    <= acc_nxt;
      rem_o    <= rem_nxt;
      ma_o     <= ma_i;
      mb_o     <= mb_i;
    end
  end

endmodule

// ----- rtl/core/float_add_mul_div_truncating_unit.sv -----
// Top level of the truncating float add/multiply/divide unit.
// Depends on famd_pkg and famd_stage.

// Pipelined unit that takes one request per cycle and returns one packed
// result per request, in order, after one align stage, one setup stage,
// FRAC_BITS+1 iteration stages and one output register. In the iteration
// chain, multiply retires one multiplier bit per stage, divide one quotient
// bit per stage after the first, and add normalizes one place per stage
// after cancellation. The whole pipeline advances together; when the output
// register holds an untaken result the pipe freezes and in_tready drops, so
// nothing is lost or repeated.
// Operands are sign | biased exponent | fraction with the hidden bit always
// assumed set; no rounding, no special values, exponent wraps.
module float_add_mul_div_truncating_unit #(
  parameter int EXP_BITS  = famd_pkg::EXP_BITS_DEF,
  parameter int FRAC_BITS = famd_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] operand_a, [63:32] operand_b
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] result
);
  import famd_pkg::*;

  localparam int E  = EXP_BITS;
  localparam int F  = FRAC_BITS;
  localparam int MW = F + 1;
  localparam int AW = 2 * MW + 1;
  localparam int RW = MW + 1;
  localparam int TW = 1 + E + F;
  localparam int OW = (TW > 32) ? TW : 32;
  localparam int NS = MW;
  localparam logic [E-1:0] BIAS = E'((1 << (E - 1)) - 1);

  logic en;

  // ---- stage 1: unpack and align ----
  logic [OW-1:0] a_x, b_x;
  logic          sa, sb;
  logic [E-1:0]  ea, eb, d;
  logic [MW-1:0] ma, mb, xa, xb;
  logic [E-1:0]  el;

  assign a_x = OW'(in_tdata[31:0]);
  assign b_x = OW'(in_tdata[63:32]);
  assign sa  = a_x[E+F];
  assign sb  = b_x[E+F];
  assign ea  = a_x[F +: E];
  assign eb  = b_x[F +: E];
  assign ma  = {1'b1, a_x[F-1:0]};
  assign mb  = {1'b1, b_x[F-1:0]};

  always_comb begin
    xa = ma;
    xb = mb;
    if (ea > eb) begin
      d  = ea - eb;
      xb = (32'(d) >= MW) ? '0 : (mb >> d);
      el = ea;
    end else begin
      d  = eb - ea;
      xa = (32'(d) >= MW) ? '0 : (ma >> d);
      el = eb;
    end
  end

  ctl_t          s1_ctl_r;
  logic          s1_sa_r, s1_sb_r;
  logic [E-1:0]  s1_ea_r, s1_eb_r, s1_el_r;
  logic [MW-1:0] s1_ma_r, s1_mb_r, s1_xa_r, s1_xb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r.vld <= 1'b0;
    end else if (en) begin
      s1_ctl_r.vld <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctl_r.op <= op_t'(in_tuser);
      s1_sa_r     <= sa;
      s1_sb_r     <= sb;
      s1_ea_r     <= ea;
      s1_eb_r     <= eb;
      s1_el_r     <= el;
      s1_ma_r     <= ma;
      s1_mb_r     <= mb;
      s1_xa_r     <= xa;
      s1_xb_r     <= xb;
    end
  end

  // ---- stage 2: add/sub, exponent, first quotient bit ----
  logic          s2_sgn;
  logic [E-1:0]  s2_ex;
  logic [AW-1:0] s2_acc;
  logic [RW-1:0] s2_rem;
  logic [RW-1:0] r;
  logic          q0;

  always_comb begin
    s2_sgn = s1_sa_r ^ s1_sb_r;
    s2_ex  = s1_ea_r + s1_eb_r - BIAS;
    s2_acc = '0;
    s2_rem = '0;
    r      = '0;
    q0     = (s1_ma_r >= s1_mb_r);
    case (s1_ctl_r.op)
      OP_ADD: begin
        if (s1_sa_r == s1_sb_r) begin
          r      = RW'(s1_xa_r) + RW'(s1_xb_r);
          s2_sgn = s1_sa_r;
        end else if (s1_xa_r >= s1_xb_r) begin
          r      = RW'(s1_xa_r - s1_xb_r);
          s2_sgn = s1_sa_r;
        end else begin
          r      = RW'(s1_xb_r - s1_xa_r);
          s2_sgn = s1_sb_r;
        end
        s2_ex = s1_el_r;
        // carry out: one place right
        if (r[MW]) begin
          r     = r >> 1;
          s2_ex = s1_el_r + 1'b1;
        end
        s2_acc = AW'(r);
      end
      OP_DIV: begin
        s2_ex  = s1_ea_r - s1_eb_r + BIAS;
        s2_rem = RW'(q0 ? (s1_ma_r - s1_mb_r) : s1_ma_r);
        s2_acc = AW'(q0);
      end
      default: ;
    endcase
  end

  ctl_t          ch_ctl [NS+1];
  logic          ch_sgn [NS+1];
  logic [E-1:0]  ch_ex  [NS+1];
  logic [AW-1:0] ch_acc [NS+1];
  logic [RW-1:0] ch_rem [NS+1];
  logic [MW-1:0] ch_ma  [NS+1];
  logic [MW-1:0] ch_mb  [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_ctl[0].vld <= 1'b0;
    end else if (en) begin
      ch_ctl[0].vld <= s1_ctl_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch_ctl[0].op <= s1_ctl_r.op;
      ch_sgn[0]    <= s2_sgn;
      ch_ex[0]     <= s2_ex;
      ch_acc[0]    <= s2_acc;
      ch_rem[0]    <= s2_rem;
      ch_ma[0]     <= s1_ma_r;
      ch_mb[0]     <= s1_mb_r;
    end
  end

  // ---- iteration chain ----
  for (genvar k = 0; k < NS; k++) begin : g_chain
    famd_stage #(.E(E), .F(F), .K(k)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ch_ctl[k]),
      .sgn_i (ch_sgn[k]),
      .ex_i  (ch_ex[k]),
      .acc_i (ch_acc[k]),
      .rem_i (ch_rem[k]),
      .ma_i  (ch_ma[k]),
      .mb_i  (ch_mb[k]),
      .ctl_o (ch_ctl[k+1]),
      .sgn_o (ch_sgn[k+1]),
      .ex_o  (ch_ex[k+1]),
      .acc_o (ch_acc[k+1]),
      .rem_o (ch_rem[k+1]),
      .ma_o  (ch_ma[k+1]),
      .mb_o  (ch_mb[k+1])
    );
  end

  // ---- final renormalize and pack ----
  logic [F+1:0]  p;
  logic [F:0]    q;
  logic [F-1:0]  frac;
  logic [E-1:0]  ef;
  logic [TW-1:0] packed_res;
  logic [31:0]   res;
  logic          vld_nxt;
  logic          out_vld_r;
  logic [31:0]   out_data_r;

  always_comb begin
    p    = ch_acc[NS][2*MW-1:F];
    q    = ch_acc[NS][F:0];
    ef   = ch_ex[NS];
    frac = '0;
    res  = '0;
    case (ch_ctl[NS].op)
      OP_MUL: begin
        if (p[F+1]) begin
          frac = p[F:1];
          ef   = ch_ex[NS] + 1'b1;
        end else begin
          frac = p[F-1:0];
        end
        packed_res = {ch_sgn[NS], ef, frac};
        res        = 32'(packed_res);
      end
      OP_DIV: begin
        if (!q[F]) begin
          frac = {q[F-2:0], 1'b0};
          ef   = ch_ex[NS] - 1'b1;
        end else begin
          frac = q[F-1:0];
        end
        packed_res = {ch_sgn[NS], ef, frac};
        res        = 32'(packed_res);
      end
      OP_ADD: begin
        frac       = ch_acc[NS][F-1:0];
        packed_res = {ch_sgn[NS], ef, frac};
        // exact cancellation gives +0
        res = (ch_acc[NS][F:0] == '0) ? '0 : 32'(packed_res);
      end
      default: begin
        packed_res = '0;
      end
    endcase
  end

  assign en      = !out_vld_r || out_tready;
  assign vld_nxt = ch_ctl[NS].vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_data_r <= res;
  end

  assign in_tready  = en;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/core/famd_checker.sv -----
// Port-level checks for the truncating float unit, bound to its top level.
// Depends on float_add_mul_div_truncating_unit.
module famd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled result holds its data
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // pipe advances whenever the output slot is free or drained
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("ready does not follow output slot");

  // reset empties the pipe
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind float_add_mul_div_truncating_unit famd_checker u_famd_checker (.*);
